// ===== rtl/ucu_pkg.sv =====
package ucu_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PSEUDO_ENABLE = 2'd0;
  localparam logic [1:0] REG_SOURCE_ADDR   = 2'd1;
  localparam logic [1:0] REG_DEST_ADDR     = 2'd2;

  // Protocol number that the UDP pseudo header carries
  localparam logic [7:0] UDP_PROTOCOL = 8'd17;

  // Width of the pseudo header part (four address halves, protocol and length)
  localparam int unsigned PSEUDO_W = 19;

  // End-of-packet request handed from the accumulator to the final sum stage
  typedef struct packed {
    logic [31:0]         sum;
    logic [PSEUDO_W-1:0] extra;
    logic                over;
  } fin_t;

endpackage

// ===== rtl/udp_internet_checksum_unit.sv =====
// Streaming internet checksum with optional UDP pseudo header. Packet bytes
// arrive one per request on the slave side, most significant byte of each
// 16-bit word first, with tlast on the final byte; one request per packet
// leaves on the master side with the inverted ones complement checksum in
// tdata and a too-long flag in tuser. A byte is taken in every cycle while
// the master side does not hold back; after its last byte is taken a result
// passes through the accumulator, the final add and the fold into the result
// register. When pseudo_header_enable is set the source and destination
// addresses, protocol 17 and the byte count are added at the end of each
// packet; configuration must be written only while no packet is in flight.
// Packets longer than 65535 bytes set too_long and their checksum is invalid.
module udp_internet_checksum_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] checksum
  output logic        m_tuser,   // [0] too_long
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ucu_pkg::*;

  logic                pseudo_header_enable;
  logic [31:0]         source_address;
  logic [31:0]         destination_address;
  logic [PSEUDO_W-1:0] pseudo_sum;

  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_last;
  logic        a_go;

  logic        fin_valid;
  fin_t        fin;
  logic        fin_taken;

  logic        c_valid;
  logic [31:0] c_total;
  logic        c_over;
  logic        c_free;
  logic        d_free;

  logic [16:0] fold1;
  logic [15:0] fold2;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pseudo_header_enable <= 1'b1;
      source_address       <= '0;
      destination_address  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PSEUDO_ENABLE: pseudo_header_enable <= cfg_data[0];
        REG_SOURCE_ADDR:   source_address       <= cfg_data;
        REG_DEST_ADDR:     destination_address  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address halves plus protocol, kept ready for the end of a packet
  always_ff @(posedge clk) begin
    pseudo_sum <= {{(PSEUDO_W-16){1'b0}}, source_address[31:16]}
                + {{(PSEUDO_W-16){1'b0}}, source_address[15:0]}
                + {{(PSEUDO_W-16){1'b0}}, destination_address[31:16]}
                + {{(PSEUDO_W-16){1'b0}}, destination_address[15:0]}
                + {{(PSEUDO_W-8){1'b0}}, UDP_PROTOCOL};
  end

  // Flow control: each stage moves when the one after it has room
  always_comb begin
    d_free    = ~m_tvalid | m_tready;
    c_free    = ~c_valid | d_free;
    fin_taken = fin_valid & c_free;
    a_go      = a_valid & (~a_last | ~fin_valid | c_free);
    s_tready  = ~a_valid | a_go;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
      a_byte  <= s_tdata;
      a_last  <= s_tlast;
    end
  end

  ucu_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .consume       (a_go),
    .data_byte     (a_byte),
    .last_byte     (a_last),
    .pseudo_enable (pseudo_header_enable),
    .pseudo_sum    (pseudo_sum),
    .fin_taken     (fin_taken),
    .fin_valid     (fin_valid),
    .fin           (fin)
  );

  // Packet sum plus pseudo header
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= fin_valid;
      c_total <= fin.sum + {{(32-PSEUDO_W){1'b0}}, fin.extra};
      c_over  <= fin.over;
    end
  end

  // Fold with end-around carry; the second fold cannot carry again
  always_comb begin
    fold1 = {1'b0, c_total[31:16]} + {1'b0, c_total[15:0]};
    fold2 = fold1[15:0] + {15'h0000, fold1[16]};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (d_free) begin
      m_tvalid <= c_valid;
      m_tdata  <= ~fold2;
      m_tuser  <= c_over;
    end
  end

endmodule

// ===== rtl/ucu_accum.sv =====
module ucu_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       consume,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  input  logic                       pseudo_enable,
  input  logic [ucu_pkg::PSEUDO_W-1:0] pseudo_sum,
  input  logic                       fin_taken,
  output logic                       fin_valid,
  output ucu_pkg::fin_t              fin
);
  import ucu_pkg::*;

  logic [31:0] sum;
  logic [15:0] byte_count;
  logic        odd_phase;
  logic [7:0]  held_high_byte;
  logic        overflow_seen;

  logic [15:0] term;
  logic        saturated;
  logic [31:0] sum_next;
  logic [15:0] byte_count_next;
  logic        overflow_next;

  // One word per byte pair; on the last byte an odd high byte is padded
  // with zero, which the same term gives when the phase is even.
  always_comb begin
    term            = odd_phase ? {held_high_byte, data_byte} : {data_byte, 8'h00};
    saturated       = (byte_count == 16'hffff);
    byte_count_next = saturated ? byte_count : byte_count + 16'd1;
    overflow_next   = overflow_seen | saturated;
    sum_next        = sum + {16'h0000, term};
  end

  // Packet state and the end-of-packet register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum            <= '0;
      byte_count     <= '0;
      odd_phase      <= 1'b0;
      held_high_byte <= '0;
      overflow_seen  <= 1'b0;
      fin_valid      <= 1'b0;
    end else begin
      // The end-of-packet register empties when taken and fills on a last byte.
      fin_valid <= (fin_valid & ~fin_taken) | (consume & last_byte);
      if (consume) begin
        if (last_byte) begin
          sum            <= '0;
          byte_count     <= '0;
          odd_phase      <= 1'b0;
          held_high_byte <= '0;
          overflow_seen  <= 1'b0;
          fin.sum        <= sum_next;
          fin.extra      <= pseudo_enable ?
                            pseudo_sum + {{(PSEUDO_W-16){1'b0}}, byte_count_next} : '0;
          fin.over       <= overflow_next;
        end else begin
          odd_phase     <= ~odd_phase;
          byte_count    <= byte_count_next;
          overflow_seen <= overflow_next;
          if (odd_phase) begin
            sum <= sum_next;
          end else begin
            held_high_byte <= data_byte;
          end
        end
      end
    end
  end

endmodule
